// File: rtl/core/ezr_pkg.sv
// shared constants, types and arctangent table for the zyx euler rotation matrix core
package ezr_pkg;

  localparam int TRIG_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES    = 24;
  localparam int OUT_FRAC_BITS   = 14;

  localparam int ANGLE_W  = 16;
  localparam int OUT_W    = 16;
  localparam int TRIG_W   = 32;
  localparam int PROD_W   = 2 * TRIG_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int FOLD_W   = 34;
  localparam int ANGLE_SH = 17;
  localparam int FRAC_Q   = 30;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [FOLD_W-1:0] fold_t;

  localparam trig_t GAIN_Q30    = 32'sh26DD3B6A;
  localparam fold_t HALF_PI_Q30 = 34'sh6487ED51;
  localparam fold_t PI_Q30      = 34'sd3373259426;

  // atan(2^-i) in q2.30
  localparam trig_t ATAN_Q30 [ATAN_ENTRIES] = '{
    32'sh3243F6A8, 32'sh1DAC6705, 32'sh0FADBAFC, 32'sh07F56EA6, 32'sh03FEAB76,
    32'sh01FFD55B, 32'sh00FFFAAA, 32'sh007FFF55, 32'sh003FFFEA, 32'sh001FFFFD,
    32'sh000FFFFF, 32'sh0007FFFF, 32'sh0003FFFF, 32'sh0001FFFF, 32'sh0000FFFF,
    32'sh00007FFF, 32'sh00003FFF, 32'sh00001FFF, 32'sh00000FFF, 32'sh000007FF,
    32'sh000003FF, 32'sh000001FF, 32'sh000000FF, 32'sh0000007F
  };

endpackage

// File: rtl/core/ezr_cordic.sv
// pipelined rotation-mode cordic giving sine and cosine of one q3.13 angle
module ezr_cordic #(
  parameter int STAGES = ezr_pkg::TRIG_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic signed [ezr_pkg::ANGLE_W-1:0] angle,
  output logic                               out_valid,
  output ezr_pkg::trig_t                     sin_q,
  output ezr_pkg::trig_t                     cos_q
);

  localparam ezr_pkg::trig_t HALF_T = ezr_pkg::HALF_PI_Q30[ezr_pkg::TRIG_W-1:0];

  ezr_pkg::fold_t z_in;
  ezr_pkg::fold_t z_fold;
  logic           flip_in;

  ezr_pkg::trig_t xs [STAGES+1];
  ezr_pkg::trig_t ys [STAGES+1];
  ezr_pkg::trig_t zs [STAGES+1];
  logic [STAGES:0] flips;
  logic [STAGES:0] vs;

  // fold by pi into the convergence range
  always_comb begin
    z_in = {{(ezr_pkg::FOLD_W - ezr_pkg::ANGLE_W - ezr_pkg::ANGLE_SH){angle[ezr_pkg::ANGLE_W-1]}},
            angle, {ezr_pkg::ANGLE_SH{1'b0}}};
    if (z_in > ezr_pkg::HALF_PI_Q30) begin
      z_fold  = z_in - ezr_pkg::PI_Q30;
      flip_in = 1'b1;
    end else if (z_in < -ezr_pkg::HALF_PI_Q30) begin
      z_fold  = z_in + ezr_pkg::PI_Q30;
      flip_in = 1'b1;
    end else begin
      z_fold  = z_in;
      flip_in = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs        <= '0;
      out_valid <= 1'b0;
    end else begin
      vs        <= {vs[STAGES-1:0], in_valid};
      out_valid <= vs[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    xs[0]    <= ezr_pkg::GAIN_Q30;
    ys[0]    <= '0;
    zs[0]    <= z_fold[ezr_pkg::TRIG_W-1:0];
    flips[0] <= flip_in;
    for (int i = 0; i < STAGES; i++) begin
      flips[i+1] <= flips[i];
      if (!zs[i][ezr_pkg::TRIG_W-1]) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - ezr_pkg::ATAN_Q30[i];
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + ezr_pkg::ATAN_Q30[i];
      end
    end
    cos_q <= flips[STAGES] ? -xs[STAGES] : xs[STAGES];
    sin_q <= flips[STAGES] ? -ys[STAGES] : ys[STAGES];
  end

  // folded angle stays within +-pi/2
  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    vs[0] |-> (zs[0] <= HALF_T) && (zs[0] >= -HALF_T))
    else $error("cordic start angle outside fold range");

  // every output word matches an input word taken the pipeline depth earlier
  a_lane_latency: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(in_valid, STAGES + 2))
    else $error("cordic word without matching input");

endmodule

// File: rtl/core/euler_zyx_to_rotation_matrix_core.sv
// top level: zyx euler angles to a 3x3 rotation matrix, fully pipelined
//
// input channel: angle_x, angle_y, angle_z (signed q3.13 radians) are taken
// at a rising edge where start is high and busy is low. busy is high only
// while rst is held, so a word can be started in every cycle otherwise.
// output channel: done pulses for one cycle with r00..r22 (signed q1.14,
// row-major, saturated to +-1.0). results appear in input order and must
// be taken in that cycle; nothing downstream can hold them.
// registers from start to done: fold register, one register per cordic
// iteration, cordic output register, cross product multiply, cross product
// round, entry multiply, round and saturate.
// throughput: one word per cycle while rst is low, set by the fully
// unrolled cordic lanes and one multiplier per product in each multiply stage.
// reset: synchronous rst clears every valid bit; words in flight are
// dropped and done stays low until new words have crossed the pipeline.
module euler_zyx_to_rotation_matrix_core #(
  parameter int TRIG_STAGES = ezr_pkg::TRIG_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [ezr_pkg::ANGLE_W-1:0] angle_x,
  input  logic signed [ezr_pkg::ANGLE_W-1:0] angle_y,
  input  logic signed [ezr_pkg::ANGLE_W-1:0] angle_z,
  output logic                               done,
  output logic signed [ezr_pkg::OUT_W-1:0]   r00,
  output logic signed [ezr_pkg::OUT_W-1:0]   r01,
  output logic signed [ezr_pkg::OUT_W-1:0]   r02,
  output logic signed [ezr_pkg::OUT_W-1:0]   r10,
  output logic signed [ezr_pkg::OUT_W-1:0]   r11,
  output logic signed [ezr_pkg::OUT_W-1:0]   r12,
  output logic signed [ezr_pkg::OUT_W-1:0]   r20,
  output logic signed [ezr_pkg::OUT_W-1:0]   r21,
  output logic signed [ezr_pkg::OUT_W-1:0]   r22
);

  localparam int LATENCY = TRIG_STAGES + 6;
  localparam int OUT_SH  = 2 * ezr_pkg::FRAC_Q - ezr_pkg::OUT_FRAC_BITS;
  localparam ezr_pkg::prod_t P_RND = ezr_pkg::prod_t'(1) <<< (ezr_pkg::FRAC_Q - 1);
  localparam ezr_pkg::sum_t  O_RND = ezr_pkg::sum_t'(1) <<< (OUT_SH - 1);
  localparam ezr_pkg::sum_t  O_LIM = ezr_pkg::sum_t'(1) <<< ezr_pkg::OUT_FRAC_BITS;

  function automatic logic [ezr_pkg::OUT_W-1:0] round_sat(input ezr_pkg::sum_t v);
    ezr_pkg::sum_t r;
    r = (v + O_RND) >>> OUT_SH;
    if (r > O_LIM) begin
      r = O_LIM;
    end else if (r < -O_LIM) begin
      r = -O_LIM;
    end
    return r[ezr_pkg::OUT_W-1:0];
  endfunction

  function automatic ezr_pkg::trig_t round_q30(input ezr_pkg::prod_t p);
    ezr_pkg::prod_t r;
    r = (p + P_RND) >>> ezr_pkg::FRAC_Q;
    return r[ezr_pkg::TRIG_W-1:0];
  endfunction

  function automatic ezr_pkg::sum_t ext(input ezr_pkg::prod_t p);
    return ezr_pkg::sum_t'(p);
  endfunction

  function automatic ezr_pkg::sum_t up(input ezr_pkg::trig_t t);
    return ezr_pkg::sum_t'(t) <<< ezr_pkg::FRAC_Q;
  endfunction

  logic accept;
  logic vx, vy, vz;
  ezr_pkg::trig_t sx, cx, sy, cy, sz, cz;

  // stage 1: cross product multiplies
  logic v1;
  ezr_pkg::prod_t pcc, pcs, psc, pss;
  ezr_pkg::trig_t sx1, cx1, sy1, cy1, sz1, cz1;
  // stage 2: cross products rounded to q2.30
  logic v2;
  ezr_pkg::trig_t cc2, cs2, sc2, ss2;
  ezr_pkg::trig_t sx2, cx2, sy2, cy2, sz2, cz2;
  // stage 3: entry multiplies
  logic v3;
  ezr_pkg::prod_t m_sysc, m_sycc, m_syss, m_sycs, m_cycz, m_cysz, m_cysx, m_cycx;
  ezr_pkg::trig_t cc3, cs3, sc3, ss3, sy3;

  assign busy   = rst;
  assign accept = start && !busy;

  ezr_cordic #(.STAGES(TRIG_STAGES)) u_cordic_x (
    .clk(clk), .rst(rst), .in_valid(accept), .angle(angle_x),
    .out_valid(vx), .sin_q(sx), .cos_q(cx)
  );

  ezr_cordic #(.STAGES(TRIG_STAGES)) u_cordic_y (
    .clk(clk), .rst(rst), .in_valid(accept), .angle(angle_y),
    .out_valid(vy), .sin_q(sy), .cos_q(cy)
  );

  ezr_cordic #(.STAGES(TRIG_STAGES)) u_cordic_z (
    .clk(clk), .rst(rst), .in_valid(accept), .angle(angle_z),
    .out_valid(vz), .sin_q(sz), .cos_q(cz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= vx;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    pcc <= cx * cz;
    pcs <= cx * sz;
    psc <= sx * cz;
    pss <= sx * sz;
    sx1 <= sx;
    cx1 <= cx;
    sy1 <= sy;
    cy1 <= cy;
    sz1 <= sz;
    cz1 <= cz;

    cc2 <= round_q30(pcc);
    cs2 <= round_q30(pcs);
    sc2 <= round_q30(psc);
    ss2 <= round_q30(pss);
    sx2 <= sx1;
    cx2 <= cx1;
    sy2 <= sy1;
    cy2 <= cy1;
    sz2 <= sz1;
    cz2 <= cz1;

    m_sysc <= sy2 * sc2;
    m_sycc <= sy2 * cc2;
    m_syss <= sy2 * ss2;
    m_sycs <= sy2 * cs2;
    m_cycz <= cy2 * cz2;
    m_cysz <= cy2 * sz2;
    m_cysx <= cy2 * sx2;
    m_cycx <= cy2 * cx2;
    cc3    <= cc2;
    cs3    <= cs2;
    sc3    <= sc2;
    ss3    <= ss2;
    sy3    <= sy2;

    r00 <= round_sat(ext(m_cycz));
    r01 <= round_sat(ext(m_sysc) - up(cs3));
    r02 <= round_sat(ext(m_sycc) + up(ss3));
    r10 <= round_sat(ext(m_cysz));
    r11 <= round_sat(ext(m_syss) + up(cc3));
    r12 <= round_sat(ext(m_sycs) - up(sc3));
    r20 <= round_sat(-up(sy3));
    r21 <= round_sat(ext(m_cysx));
    r22 <= round_sat(ext(m_cycx));
  end

  // the three lanes stay in step
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (vx == vy) && (vy == vz))
    else $error("cordic lanes out of step");

  // every accepted word gives exactly one result after the pipeline depth
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted word produced no result");

  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without an accepted word");

endmodule
